### hdl/checkerboard_swap_sampler_core_macros.svh
// Assertion macros for the checkerboard swap sampler core.
`ifndef CHECKERBOARD_SWAP_SAMPLER_CORE_MACROS_SVH
`define CHECKERBOARD_SWAP_SAMPLER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define CBSS_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define CBSS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`else

`define CBSS_ASSERT_IMP(label, clk_s, rstn_s, ante, cons)
`define CBSS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)

`endif

`endif

### hdl/cbss_pkg.sv
// Shared types and constants for the checkerboard swap sampler.
package cbss_pkg;

	// Fixed field widths
	localparam int ACTION_W = 2;
	localparam int IDX_W    = 4;
	localparam int WIN_W    = 16;
	localparam int STATUS_W = 2;
	localparam int DOUT_W   = 17;
	localparam int CFG_W    = 5;
	localparam int RAND_W   = 32;
	localparam int RCNT_W   = $clog2(RAND_W + 1);

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SWAP  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SAME  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FIXED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// Register indexes
	localparam logic CFG_NUM_ROWS = 1'b0;
	localparam logic CFG_NUM_COLS = 1'b1;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
	localparam logic [CFG_W-1:0] IDX_CAP   = 5'd16;

	// Corner order: 0 = (r0,c0), 1 = (r0,c1), 2 = (r1,c1), 3 = (r1,c0)
	localparam logic [1:0] LAST_CORNER = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_FETCH,
		S_CAPT,
		S_EVAL,
		S_HIGH,
		S_LOW,
		S_SPAN,
		S_DSTART,
		S_DIV,
		S_APPLY,
		S_WRITE,
		S_DONE
	} state_t;

endpackage

### hdl/cbss_store.sv
// Single-port entry store: weight plus fixed mark, registered read data.
module cbss_store #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 17
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DATA_W-1:0]        wdata,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// One access per cycle, write wins
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/cbss_mod.sv
// Restoring bit-serial remainder unit: one dividend bit per cycle.
module cbss_mod #(
	parameter int DIV_BITS = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cbss_pkg::RAND_W-1:0] dividend,
	input  logic [DIV_BITS-1:0]        divisor,
	output logic [DIV_BITS-1:0]        rem,
	output logic                       done
);

	logic                        busy_q;
	logic [cbss_pkg::RCNT_W-1:0] cnt_q;
	logic [cbss_pkg::RAND_W-1:0] dvd_q;
	logic [DIV_BITS-1:0]         dsr_q;
	logic [DIV_BITS-1:0]         rem_q;
	logic [DIV_BITS:0]           trial;
	logic                        fits;

	// Shift in next dividend bit, subtract when it fits
	assign trial = {rem_q, dvd_q[cbss_pkg::RAND_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= cbss_pkg::RCNT_W'(cbss_pkg::RAND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - cbss_pkg::RCNT_W'(1);
			if (cnt_q == cbss_pkg::RCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= fits ? DIV_BITS'(trial - {1'b0, dsr_q}) : DIV_BITS'(trial);
		end
	end

	assign rem  = rem_q;
	assign done = !busy_q;

endmodule

### hdl/checkerboard_swap_sampler_core.sv
// Top level: request sequencer, range checks, bounds and swap update.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | to core   | in_valid / in_stall    | action row col weight_in fixed_in
//          |           |                        | row_first row_second col_first
//          |           |                        | col_second rand_value
//  out     | from core | out_valid / out_stall  | status weight_out fixed_out delta_out
//  cfg     | to core   | cfg_write              | cfg_index cfg_data
//
// One request at a time. A read makes one store read; an accepted swap makes four
// store reads and four store writes on the single store port, with the 32-step
// bit-serial remainder unit run between them.
// After reset the store is cleared, one entry a cycle, all MAX_ROWS*MAX_COLS entries,
// with in_stall high. A finished result waits in the output register while the
// next request is taken; the core holds its next result until that one leaves.
`include "checkerboard_swap_sampler_core_macros.svh"

module checkerboard_swap_sampler_core #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cbss_pkg::ACTION_W-1:0]       action,
	input  logic [cbss_pkg::IDX_W-1:0]          row,
	input  logic [cbss_pkg::IDX_W-1:0]          col,
	input  logic [cbss_pkg::WIN_W-1:0]          weight_in,
	input  logic                                fixed_in,
	input  logic [cbss_pkg::IDX_W-1:0]          row_first,
	input  logic [cbss_pkg::IDX_W-1:0]          row_second,
	input  logic [cbss_pkg::IDX_W-1:0]          col_first,
	input  logic [cbss_pkg::IDX_W-1:0]          col_second,
	input  logic [cbss_pkg::RAND_W-1:0]         rand_value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cbss_pkg::STATUS_W-1:0]       status,
	output logic [cbss_pkg::WIN_W-1:0]          weight_out,
	output logic                                fixed_out,
	output logic signed [cbss_pkg::DOUT_W-1:0]  delta_out,
	// configuration
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [cbss_pkg::CFG_W-1:0]          cfg_data
);

	localparam int DEPTH   = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int ENTRY_W = WEIGHT_BITS + 1;
	localparam int SPAN_W  = WEIGHT_BITS + 1;
	localparam int DELTA_W = WEIGHT_BITS + 2;
	localparam logic [cbss_pkg::CFG_W-1:0] ROW_CAP =
		cbss_pkg::CFG_W'((MAX_ROWS > 16) ? 16 : MAX_ROWS);
	localparam logic [cbss_pkg::CFG_W-1:0] COL_CAP =
		cbss_pkg::CFG_W'((MAX_COLS > 16) ? 16 : MAX_COLS);

	cbss_pkg::state_t state_q, state_d;

	// configuration
	logic [cbss_pkg::CFG_W-1:0] num_rows_q, num_cols_q;
	logic [cbss_pkg::CFG_W-1:0] rows_used, cols_used;

	// latched request
	logic [cbss_pkg::ACTION_W-1:0] act_q;
	logic [cbss_pkg::IDX_W-1:0]    row_q, col_q, r0_q, r1_q, c0_q, c1_q;
	logic [WEIGHT_BITS-1:0]        wgt_q;
	logic                          fix_q;
	logic [cbss_pkg::RAND_W-1:0]   rnd_q;

	// sequencer counters
	logic [1:0]        k_q;
	logic [ADDR_W-1:0] clr_q;

	// swap working registers
	logic [WEIGHT_BITS-1:0]    w_q [4];
	logic                      fixed_any_q;
	logic [WEIGHT_BITS-1:0]    hi_q, ln_q;
	logic [SPAN_W-1:0]         span_q;
	logic signed [DELTA_W-1:0] delta_q;

	// pending result
	logic [cbss_pkg::STATUS_W-1:0] res_status_q;
	logic [cbss_pkg::WIN_W-1:0]    res_wout_q;
	logic                          res_fout_q;
	logic signed [DELTA_W-1:0]     res_delta_q;

	// output register
	logic                                out_valid_q;
	logic [cbss_pkg::STATUS_W-1:0]       out_status_q;
	logic [cbss_pkg::WIN_W-1:0]          out_wout_q;
	logic                                out_fout_q;
	logic signed [cbss_pkg::DOUT_W-1:0]  out_delta_q;

	// store and remainder unit hookup
	logic                 mem_en, mem_we;
	logic [ADDR_W-1:0]    mem_addr;
	logic [ENTRY_W-1:0]   mem_wdata, mem_rdata;
	logic                 div_start, div_done;
	logic [SPAN_W-1:0]    div_rem;

	// misc combinational
	logic                          accept, out_free;
	logic                          rw_ok, sw_range, sw_same;
	logic [cbss_pkg::STATUS_W-1:0] chk_status;
	logic [cbss_pkg::IDX_W-1:0]    sel_row, sel_col;
	logic [ADDR_W-1:0]             cell_addr;
	logic [WEIGHT_BITS-1:0]        w_cur, new_w;
	logic [WEIGHT_BITS-1:0]        hi_min, ln_min;
	logic signed [DELTA_W-1:0]     delta_calc;

	function automatic logic [WEIGHT_BITS-1:0] min2(
		input logic [WEIGHT_BITS-1:0] a,
		input logic [WEIGHT_BITS-1:0] b
	);
		return (a < b) ? a : b;
	endfunction

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// rows/cols in use, clamped to the array size
	assign rows_used = (num_rows_q > ROW_CAP) ? ROW_CAP : num_rows_q;
	assign cols_used = (num_cols_q > COL_CAP) ? COL_CAP : num_cols_q;

	// index checks on the latched request
	assign rw_ok    = ({1'b0, row_q} < rows_used) && ({1'b0, col_q} < cols_used);
	assign sw_range = ({1'b0, r0_q} < rows_used) && ({1'b0, c0_q} < cols_used) &&
		({1'b0, r1_q} < rows_used) && ({1'b0, c1_q} < cols_used);
	assign sw_same  = (r0_q == r1_q) || (c0_q == c1_q);

	always_comb begin
		case (act_q)
			cbss_pkg::ACT_WRITE, cbss_pkg::ACT_READ: begin
				chk_status = rw_ok ? cbss_pkg::ST_OK : cbss_pkg::ST_RANGE;
			end
			cbss_pkg::ACT_SWAP: begin
				if (!sw_range) begin
					chk_status = cbss_pkg::ST_RANGE;
				end else if (sw_same) begin
					chk_status = cbss_pkg::ST_SAME;
				end else begin
					chk_status = cbss_pkg::ST_OK;
				end
			end
			default: chk_status = cbss_pkg::ST_OK;
		endcase
	end

	// entry address: plain row/col, or swap corner k
	assign sel_row = (act_q != cbss_pkg::ACT_SWAP) ? row_q : (k_q[1] ? r1_q : r0_q);
	assign sel_col = (act_q != cbss_pkg::ACT_SWAP) ? col_q :
		((k_q[0] ^ k_q[1]) ? c1_q : c0_q);
	assign cell_addr = ADDR_W'(ADDR_W'(sel_row) * ADDR_W'(MAX_COLS)) + ADDR_W'(sel_col);

	// bounds: M - w is ~w
	assign hi_min = min2(min2(w_q[1], w_q[3]), min2(~w_q[0], ~w_q[2]));
	assign ln_min = min2(min2(w_q[0], w_q[2]), min2(~w_q[1], ~w_q[3]));

	assign delta_calc = $signed({1'b0, div_rem}) - $signed({2'b00, ln_q});

	// corners 0 and 2 gain delta, 1 and 3 lose it
	assign w_cur = w_q[k_q];
	assign new_w = k_q[0] ? WEIGHT_BITS'($signed({2'b00, w_cur}) - delta_q)
		: WEIGHT_BITS'($signed({2'b00, w_cur}) + delta_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cbss_pkg::S_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) state_d = cbss_pkg::S_IDLE;
			end
			cbss_pkg::S_IDLE: begin
				if (accept) state_d = cbss_pkg::S_CHECK;
			end
			cbss_pkg::S_CHECK: begin
				if ((act_q == cbss_pkg::ACT_READ || act_q == cbss_pkg::ACT_SWAP) &&
					chk_status == cbss_pkg::ST_OK) begin
					state_d = cbss_pkg::S_FETCH;
				end else begin
					state_d = cbss_pkg::S_DONE;
				end
			end
			cbss_pkg::S_FETCH: state_d = cbss_pkg::S_CAPT;
			cbss_pkg::S_CAPT: begin
				if (act_q == cbss_pkg::ACT_READ) begin
					state_d = cbss_pkg::S_DONE;
				end else if (k_q == cbss_pkg::LAST_CORNER) begin
					state_d = cbss_pkg::S_EVAL;
				end else begin
					state_d = cbss_pkg::S_FETCH;
				end
			end
			cbss_pkg::S_EVAL: begin
				state_d = fixed_any_q ? cbss_pkg::S_DONE : cbss_pkg::S_HIGH;
			end
			cbss_pkg::S_HIGH:   state_d = cbss_pkg::S_LOW;
			cbss_pkg::S_LOW:    state_d = cbss_pkg::S_SPAN;
			cbss_pkg::S_SPAN:   state_d = cbss_pkg::S_DSTART;
			cbss_pkg::S_DSTART: state_d = cbss_pkg::S_DIV;
			cbss_pkg::S_DIV: begin
				if (div_done) state_d = cbss_pkg::S_APPLY;
			end
			cbss_pkg::S_APPLY: state_d = cbss_pkg::S_WRITE;
			cbss_pkg::S_WRITE: begin
				if (k_q == cbss_pkg::LAST_CORNER) state_d = cbss_pkg::S_DONE;
			end
			cbss_pkg::S_DONE: begin
				if (out_free) state_d = cbss_pkg::S_IDLE;
			end
			default: state_d = cbss_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = cell_addr;
		mem_wdata = {1'b0, new_w};
		div_start = 1'b0;
		in_stall  = 1'b1;
		case (state_q)
			cbss_pkg::S_CLEAR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			cbss_pkg::S_IDLE: in_stall = 1'b0;
			cbss_pkg::S_CHECK: begin
				mem_wdata = {fix_q, wgt_q};
				if (act_q == cbss_pkg::ACT_WRITE && rw_ok) begin
					mem_en = 1'b1;
					mem_we = 1'b1;
				end
			end
			cbss_pkg::S_FETCH:  mem_en = 1'b1;
			cbss_pkg::S_DSTART: div_start = 1'b1;
			cbss_pkg::S_WRITE: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbss_pkg::S_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			num_rows_q  <= cbss_pkg::CFG_RESET;
			num_cols_q  <= cbss_pkg::CFG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == cbss_pkg::S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			case (state_q)
				cbss_pkg::S_CHECK, cbss_pkg::S_APPLY: k_q <= '0;
				cbss_pkg::S_CAPT, cbss_pkg::S_WRITE: k_q <= k_q + 2'd1;
				default: ;
			endcase
			if (cfg_write) begin
				case (cfg_index)
					cbss_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data;
					cbss_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == cbss_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request latch and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			row_q <= row;
			col_q <= col;
			wgt_q <= WEIGHT_BITS'(weight_in);
			fix_q <= fixed_in;
			r0_q  <= row_first;
			r1_q  <= row_second;
			c0_q  <= col_first;
			c1_q  <= col_second;
			rnd_q <= rand_value;
		end
		case (state_q)
			cbss_pkg::S_CHECK: begin
				fixed_any_q  <= 1'b0;
				res_status_q <= chk_status;
				res_wout_q   <= '0;
				res_fout_q   <= 1'b0;
				res_delta_q  <= '0;
			end
			cbss_pkg::S_CAPT: begin
				if (act_q == cbss_pkg::ACT_READ) begin
					res_wout_q <= cbss_pkg::WIN_W'(mem_rdata[WEIGHT_BITS-1:0]);
					res_fout_q <= mem_rdata[WEIGHT_BITS];
				end else begin
					w_q[k_q]    <= mem_rdata[WEIGHT_BITS-1:0];
					fixed_any_q <= fixed_any_q | mem_rdata[WEIGHT_BITS];
				end
			end
			cbss_pkg::S_EVAL: begin
				if (fixed_any_q) res_status_q <= cbss_pkg::ST_FIXED;
			end
			cbss_pkg::S_HIGH: hi_q <= hi_min;
			cbss_pkg::S_LOW:  ln_q <= ln_min;
			cbss_pkg::S_SPAN: span_q <= {1'b0, hi_q} + {1'b0, ln_q} + SPAN_W'(1);
			cbss_pkg::S_APPLY: begin
				delta_q     <= delta_calc;
				res_delta_q <= delta_calc;
			end
			default: ;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == cbss_pkg::S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_wout_q   <= res_wout_q;
			out_fout_q   <= res_fout_q;
			out_delta_q  <= cbss_pkg::DOUT_W'(res_delta_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign weight_out = out_wout_q;
	assign fixed_out  = out_fout_q;
	assign delta_out  = out_delta_q;

	cbss_store #(
		.DEPTH (DEPTH),
		.DATA_W(ENTRY_W)
	) u_store (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	cbss_mod #(
		.DIV_BITS(SPAN_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rnd_q),
		.divisor (span_q),
		.rem     (div_rem),
		.done    (div_done)
	);

	// checks
	`CBSS_ASSERT_NEXT(a_accept_to_check, clk, arst_n, accept, state_q == cbss_pkg::S_CHECK)
	`CBSS_ASSERT_IMP(a_rem_below_span, clk, arst_n, state_q == cbss_pkg::S_DIV && div_done, div_rem < span_q)
	`CBSS_ASSERT_IMP(a_delta_in_support, clk, arst_n, state_q == cbss_pkg::S_WRITE, (delta_q <= $signed({2'b00, hi_q})) && (delta_q >= -$signed({2'b00, ln_q})))
	`CBSS_ASSERT_IMP(a_result_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == cbss_pkg::S_DONE)

endmodule
